// ===== hw/rtl/process_handle_deque_defines.svh =====
`ifndef PROCESS_HANDLE_DEQUE_DEFINES_SVH
`define PROCESS_HANDLE_DEQUE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PHD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PHD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/phd_pkg.sv =====
package phd_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4,
    CMD_FLUSH      = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic       en;
    logic [2:0] cmd;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/phd_if.sv =====
interface phd_cmd_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          cmd;
  logic [ID_WIDTH-1:0] proc_id;

  modport source (output valid, output cmd, output proc_id, input ready);
  modport sink   (input valid, input cmd, input proc_id, output ready);
endinterface

interface phd_rsp_if #(
  parameter int ID_WIDTH = 16,
  parameter int CNT_W    = 5
);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] out_id;
  logic                out_valid;
  logic [1:0]          status;
  logic [CNT_W-1:0]    occupancy;
  logic                last;

  modport source (output valid, output out_id, output out_valid, output status,
                  output occupancy, output last, input ready);
  modport sink   (input valid, input out_id, input out_valid, input status,
                  input occupancy, input last, output ready);
endinterface

// ===== hw/rtl/process_handle_deque.sv =====
// channel | dir | handshake          | payload
// cmd_i   | in  | valid / ready      | cmd, proc_id
// rsp_o   | out | valid / ready      | out_id, out_valid, status, occupancy, last
//
// Each command is captured in StIdle, then updates the cell chain in StExec once the output register is free.
// A flush emits one item per cycle while rsp_o is not stalled, DEPTH items at most for a full deque.
// The match search and tail pick ripple combinationally through the cell chain.
// Reset clears the count and the handshake state; the id cells are not reset.
// A stalled rsp_o holds its item; the chain waits until the output register frees.
module process_handle_deque #(
  parameter  int DEPTH    = 16,
  parameter  int ID_WIDTH = 16,
  localparam int CntW     = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  phd_cmd_if.sink          cmd_i,
  phd_rsp_if.source        rsp_o
);
  import phd_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                state_q, state_d;
  logic [2:0]          cmd_q;
  logic [ID_WIDTH-1:0] key_q;
  logic [CntW-1:0]     count_q, count_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [ID_WIDTH-1:0] rsp_id_q, rsp_id_d;
  logic                rsp_oval_q, rsp_oval_d;
  status_e             rsp_status_q, rsp_status_d;
  logic [CntW-1:0]     rsp_occ_q;
  logic                rsp_last_q, rsp_last_d;

  logic                slot_free, fire, full, empty;
  cell_ctl_t           ctl;

  logic [ID_WIDTH-1:0] id_w   [DEPTH];
  logic                hit_w  [DEPTH+1];
  logic [ID_WIDTH-1:0] tail_w [DEPTH+1];

  assign hit_w[0]  = 1'b0;
  assign tail_w[0] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [ID_WIDTH-1:0] left_id, right_id;
    if (k == 0) begin : g_first
      assign left_id = '0;
    end else begin : g_mid
      assign left_id = id_w[k-1];
    end
    if (k == DEPTH - 1) begin : g_end
      assign right_id = '0;
    end else begin : g_inner
      assign right_id = id_w[k+1];
    end
    phd_cell #(.IDX(k), .ID_WIDTH(ID_WIDTH), .CNT_W(CntW)) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .key_i      (key_q),
      .count_i    (count_q),
      .left_id_i  (left_id),
      .right_id_i (right_id),
      .hit_i      (hit_w[k]),
      .tail_i     (tail_w[k]),
      .id_o       (id_w[k]),
      .hit_o      (hit_w[k+1]),
      .tail_o     (tail_w[k+1])
    );
  end

  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign fire        = (state_q == StExec) && slot_free;
  assign full        = count_q == CntW'(DEPTH);
  assign empty       = count_q == '0;
  assign cmd_i.ready = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rsp_id_d     = '0;
    rsp_oval_d   = 1'b0;
    rsp_status_d = ST_OK;
    rsp_last_d   = 1'b1;
    ctl.en       = 1'b0;
    ctl.cmd      = cmd_q;

    if (state_q == StIdle && cmd_i.valid) state_d = StExec;

    if (fire) begin
      state_d = StIdle;
      ctl.en  = 1'b1;
      case (cmd_q)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (full) begin
            rsp_status_d = ST_FULL;
            ctl.en       = 1'b0;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            rsp_id_d   = id_w[0];
            rsp_oval_d = 1'b1;
            count_d    = count_q - CntW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            rsp_id_d   = tail_w[DEPTH];
            rsp_oval_d = 1'b1;
            count_d    = count_q - CntW'(1);
          end
        end
        CMD_REMOVE: begin
          if (hit_w[DEPTH]) count_d = count_q - CntW'(1);
          else              rsp_status_d = ST_NOT_FOUND;
        end
        CMD_FLUSH: begin
          if (empty) begin
            rsp_status_d = ST_EMPTY;
          end else begin
            rsp_id_d   = id_w[0];
            rsp_oval_d = 1'b1;
            count_d    = count_q - CntW'(1);
            rsp_last_d = count_q == CntW'(1);
            if (count_q != CntW'(1)) state_d = StExec;
          end
        end
        default: begin
          ctl.en = 1'b0;
        end
      endcase
    end

    if (fire)              rsp_valid_d = 1'b1;
    else if (rsp_o.ready)  rsp_valid_d = 1'b0;
    else                   rsp_valid_d = rsp_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q <= cmd_i.cmd;
      key_q <= cmd_i.proc_id;
    end
    if (fire) begin
      rsp_id_q     <= rsp_id_d;
      rsp_oval_q   <= rsp_oval_d;
      rsp_status_q <= rsp_status_d;
      rsp_occ_q    <= count_d;
      rsp_last_q   <= rsp_last_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.out_id    = rsp_id_q;
  assign rsp_o.out_valid = rsp_oval_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.occupancy = rsp_occ_q;
  assign rsp_o.last      = rsp_last_q;

endmodule

// ===== hw/rtl/phd_cell.sv =====
module phd_cell #(
  parameter int IDX      = 0,
  parameter int ID_WIDTH = 16,
  parameter int CNT_W    = 5
) (
  input  logic                clk_i,
  input  phd_pkg::cell_ctl_t  ctl_i,
  input  logic [ID_WIDTH-1:0] key_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [ID_WIDTH-1:0] left_id_i,
  input  logic [ID_WIDTH-1:0] right_id_i,
  input  logic                hit_i,
  input  logic [ID_WIDTH-1:0] tail_i,
  output logic [ID_WIDTH-1:0] id_o,
  output logic                hit_o,
  output logic [ID_WIDTH-1:0] tail_o
);
  import phd_pkg::*;

  logic [ID_WIDTH-1:0] id_q, id_d;
  logic                occupied;
  logic                is_tail;

  assign occupied = CNT_W'(IDX) < count_i;
  assign is_tail  = CNT_W'(IDX + 1) == count_i;
  assign hit_o    = hit_i | (occupied && (id_q == key_i));
  assign tail_o   = tail_i | ({ID_WIDTH{is_tail}} & id_q);
  assign id_o     = id_q;

  always_comb begin
    id_d = id_q;
    if (ctl_i.en) begin
      case (ctl_i.cmd)
        CMD_PUSH_BACK: begin
          if (count_i == CNT_W'(IDX)) id_d = key_i;
        end
        CMD_PUSH_FRONT: begin
          id_d = (IDX == 0) ? key_i : left_id_i;
        end
        CMD_POP_FRONT, CMD_FLUSH: begin
          id_d = right_id_i;
        end
        CMD_REMOVE: begin
          // everything from the first match onward moves one toward the front
          if (hit_o) id_d = right_id_i;
        end
        default: begin
          id_d = id_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

// ===== hw/rtl/phd_checker.sv =====
`include "process_handle_deque_defines.svh"

module phd_checker #(
  parameter  int DEPTH    = 16,
  parameter  int ID_WIDTH = 16,
  localparam int CntW     = $clog2(DEPTH + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [ID_WIDTH-1:0] out_id_i,
  input logic                out_valid_i,
  input logic [1:0]          status_i,
  input logic [CntW-1:0]     occupancy_i,
  input logic                last_i
);
  import phd_pkg::*;

  `PHD_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(out_id_i) && $stable(status_i) && $stable(occupancy_i) && $stable(last_i), "stalled item changed")
  `PHD_ASSERT_IMP(a_occ_max, clk_i, rst_ni, rsp_valid_i, occupancy_i <= CntW'(DEPTH), "occupancy above depth")
  `PHD_ASSERT_IMP(a_id_zero, clk_i, rst_ni, rsp_valid_i && !out_valid_i, out_id_i == '0, "id not zero without entry")
  `PHD_ASSERT_IMP(a_flush_mid, clk_i, rst_ni, rsp_valid_i && !last_i, out_valid_i && status_i == ST_OK && occupancy_i != '0, "bad flush run item")
  `PHD_ASSERT_IMP(a_full_occ, clk_i, rst_ni, rsp_valid_i && status_i == ST_FULL, occupancy_i == CntW'(DEPTH), "full status below depth")

endmodule

bind process_handle_deque phd_checker #(
  .DEPTH    (DEPTH),
  .ID_WIDTH (ID_WIDTH)
) u_phd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .out_id_i    (rsp_o.out_id),
  .out_valid_i (rsp_o.out_valid),
  .status_i    (rsp_o.status),
  .occupancy_i (rsp_o.occupancy),
  .last_i      (rsp_o.last)
);
